### hdl/rle_pkg.sv
// shared constants and control types for the run-length to bitmap expander
`timescale 1ns / 1ps
`default_nettype none
package rle_pkg;

  localparam int MAX_RUN    = 2048;
  localparam int MAX_WORDS  = 33;
  localparam int HARD_CLIP  = MAX_WORDS * 64 - 7;
  localparam int CLIP_LIMIT = (MAX_RUN < HARD_CLIP) ? MAX_RUN : HARD_CLIP;

  localparam int RUN_W   = 12;
  localparam int TOTAL_W = 12;
  localparam int BYTES_W = TOTAL_W - 3;

  localparam logic [RUN_W-1:0] CLIP_VAL = RUN_W'(CLIP_LIMIT);

  localparam logic [3:0] WORD_BYTES = 4'd8;

  typedef struct packed {
    logic load;
    logic advance;
  } rle_cmd_t;

  typedef struct packed {
    logic has_bytes;
    logic last;
  } rle_status_t;

endpackage
`default_nettype wire

### hdl/rle_ctrl.sv
// controller: accept and emit state machine
`timescale 1ns / 1ps
`default_nettype none
module rle_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire rle_pkg::rle_status_t status,
  output rle_pkg::rle_cmd_t        cmd
);
  import rle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  assign in_stall    = (state != ST_IDLE);
  assign out_valid   = (state == ST_EMIT);
  assign cmd.load    = in_valid && (state == ST_IDLE);
  assign cmd.advance = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load && status.has_bytes) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.advance && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### hdl/rle_datapath.sv
// datapath: partial byte, colour, byte counter and word assembly
`timescale 1ns / 1ps
`default_nettype none
module rle_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rle_pkg::rle_cmd_t          cmd,
  input  wire logic [rle_pkg::RUN_W-1:0]  run_length,
  input  wire logic                       is_eol,
  output rle_pkg::rle_status_t            status,
  output logic [63:0]                     packed_bytes,
  output logic [3:0]                      byte_count,
  output logic                            last_of_run,
  output logic                            run_clipped
);
  import rle_pkg::*;

  logic [6:0]         partial_bits;
  logic [2:0]         partial_count;
  logic               next_colour_black;
  logic               run_black;
  logic               run_clip;
  logic               first;
  logic [7:0]         head_byte;
  logic [BYTES_W-1:0] bytes_left;

  logic [RUN_W-1:0]   n_clip;
  logic               clip_in;
  logic [TOTAL_W-1:0] total;
  logic [15:0]        head_shift;
  logic [7:0]         head_next;
  logic [7:0]         short_bits;
  logic [7:0]         tail_mask;
  logic [7:0]         fill_byte;
  logic [3:0]         nb;

  assign clip_in = (run_length > CLIP_VAL);
  assign n_clip  = clip_in ? CLIP_VAL : run_length;
  assign total   = TOTAL_W'(n_clip) + TOTAL_W'(partial_count);

  assign head_shift = 16'({1'b0, partial_bits}) << (4'd8 - 4'(partial_count));
  assign head_next  = head_shift[7:0] |
                      (next_colour_black ? (8'hFF >> partial_count) : 8'h00);

  // run stays inside the partial byte
  assign short_bits = (8'({1'b0, partial_bits}) << n_clip[2:0]) |
                      (next_colour_black ? ((8'h01 << n_clip[2:0]) - 8'h01) : 8'h00);
  // remainder after the last completed byte is all run colour
  assign tail_mask  = (8'h01 << total[2:0]) - 8'h01;

  assign status.has_bytes = !is_eol && (total[TOTAL_W-1:3] != '0);
  assign status.last      = (bytes_left <= BYTES_W'(WORD_BYTES));

  assign fill_byte = run_black ? 8'hFF : 8'h00;
  assign nb        = status.last ? bytes_left[3:0] : WORD_BYTES;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        packed_bytes[63-8*i -: 8] = (i == 0 && first) ? head_byte : fill_byte;
      end else begin
        packed_bytes[63-8*i -: 8] = 8'h00;
      end
    end
  end

  assign byte_count  = nb;
  assign last_of_run = status.last;
  assign run_clipped = run_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_bits      <= '0;
      partial_count     <= '0;
      next_colour_black <= 1'b0;
    end else if (cmd.load) begin
      if (is_eol) begin
        next_colour_black <= 1'b0;
      end else begin
        next_colour_black <= !next_colour_black;
        partial_count     <= total[2:0];
        if (total[TOTAL_W-1:3] == '0) begin
          partial_bits <= short_bits[6:0];
        end else begin
          partial_bits <= next_colour_black ? tail_mask[6:0] : 7'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_black  <= next_colour_black;
      run_clip   <= clip_in;
      first      <= 1'b1;
      head_byte  <= head_next;
      bytes_left <= total[TOTAL_W-1:3];
    end else if (cmd.advance) begin
      first      <= 1'b0;
      bytes_left <= bytes_left - BYTES_W'(nb);
    end
  end

endmodule
`default_nettype wire

### hdl/run_length_to_bitmap_expander_top.sv
// top level of the run-length to bitmap expander
//
//  channel  handshake             payload
//  in       in_valid / in_stall   run_length[11:0], is_eol
//  out      out_valid / out_stall packed_bytes[63:0], byte_count[3:0],
//                                 last_of_run, run_clipped
//
// an item is taken in the idle state, then its output words (up to 32 words) are emitted;
// the byte counter in the datapath counts down the bytes left, up to eight per word
// items causing no word (end of line, short runs) leave the state machine idle
// rst clears colour, partial byte and the state machine
// input is stalled while words of the current item are emitted
`timescale 1ns / 1ps
`default_nettype none
module run_length_to_bitmap_expander_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [rle_pkg::RUN_W-1:0] run_length,
  input  wire logic                      is_eol,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [63:0]                    packed_bytes,
  output logic [3:0]                     byte_count,
  output logic                           last_of_run,
  output logic                           run_clipped
);
  import rle_pkg::*;

  rle_cmd_t    cmd;
  rle_status_t status;

  rle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rle_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .run_length   (run_length),
    .is_eol       (is_eol),
    .status       (status),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .last_of_run  (last_of_run),
    .run_clipped  (run_clipped)
  );

endmodule
`default_nettype wire

### hdl/rle_checker.sv
// port-level checks for the run-length to bitmap expander and their binding
`timescale 1ns / 1ps
`default_nettype none
module rle_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] packed_bytes,
  input wire logic [3:0]  byte_count,
  input wire logic        last_of_run
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count >= 4'd1 && byte_count <= 4'd8))
    else $error("byte count out of range");

  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> (byte_count == 4'd8))
    else $error("non-final word not full");

  a_busy_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while words pending");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> ($past(last_of_run) && !$past(out_stall)))
    else $error("output ended before final word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(packed_bytes)))
    else $error("stalled output changed");

endmodule

bind run_length_to_bitmap_expander_top rle_checker u_rle_checker (.*);
`default_nettype wire

### tb/bitmap_word_checker.sv
// checker that predicts packed bitmap words from accepted runs and compares every result
`timescale 1ns / 1ps
module bitmap_word_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [rle_pkg::RUN_W-1:0] run_length,
  input  logic                      is_eol,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [63:0]               packed_bytes,
  input  logic [3:0]                byte_count,
  input  logic                      last_of_run,
  input  logic                      run_clipped,
  output int unsigned               errors,
  output int unsigned               pending
);

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic        clipped;
  } bitmap_word_t;

  bitmap_word_t words_due[$];

  logic [7:0] byte_acc;
  int unsigned bit_count;
  logic colour_black;

  initial begin
    errors = 0;
    pending = 0;
    byte_acc = '0;
    bit_count = 0;
    colour_black = 1'b0;
  end

  task automatic expand_run(input logic [rle_pkg::RUN_W-1:0] len, input logic eol);
    int unsigned n;
    int unsigned i;
    int unsigned nbytes;
    int unsigned made_count;
    logic clipped;
    logic black;
    logic [63:0] word;
    bitmap_word_t made[rle_pkg::MAX_WORDS];
    if (eol) begin
      colour_black = 1'b0;
      return;
    end
    n = len;
    clipped = 1'b0;
    if (n > rle_pkg::CLIP_LIMIT) begin
      n = rle_pkg::CLIP_LIMIT;
      clipped = 1'b1;
    end
    black = colour_black;
    colour_black = ~black;
    word = '0;
    nbytes = 0;
    made_count = 0;
    for (i = 0; i < n; i++) begin
      byte_acc = {byte_acc[6:0], black};
      bit_count++;
      if (bit_count == 8) begin
        word[63 - 8 * nbytes -: 8] = byte_acc;
        nbytes++;
        byte_acc = '0;
        bit_count = 0;
        if (nbytes == 8) begin
          made[made_count] = '{word, 4'(nbytes), 1'b0, clipped};
          made_count++;
          word = '0;
          nbytes = 0;
        end
      end
    end
    if (nbytes > 0) begin
      made[made_count] = '{word, 4'(nbytes), 1'b0, clipped};
      made_count++;
    end
    if (made_count > 0) made[made_count - 1].last = 1'b1;
    for (i = 0; i < made_count; i++) words_due.push_back(made[i]);
  endtask

  task automatic check_word();
    bitmap_word_t want;
    if (words_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected item, expected none, got packed_bytes %h byte_count %0d last %b clipped %b",
               $time, packed_bytes, byte_count, last_of_run, run_clipped);
      return;
    end
    want = words_due.pop_front();
    if (packed_bytes !== want.bytes) begin
      errors++;
      $display("%0t: packed_bytes expected %h got %h", $time, want.bytes, packed_bytes);
    end
    if (byte_count !== want.count) begin
      errors++;
      $display("%0t: byte_count expected %0d got %0d", $time, want.count, byte_count);
    end
    if (last_of_run !== want.last) begin
      errors++;
      $display("%0t: last_of_run expected %b got %b", $time, want.last, last_of_run);
    end
    if (run_clipped !== want.clipped) begin
      errors++;
      $display("%0t: run_clipped expected %b got %b", $time, want.clipped, run_clipped);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_acc = '0;
      bit_count = 0;
      colour_black = 1'b0;
      words_due.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) expand_run(run_length, is_eol);
    end
    pending = words_due.size();
  end

endmodule

### tb/run_length_to_bitmap_expander_top_tb.sv
// top of the testbench: clock, reset, run stimulus, output stalls and the final verdict
`timescale 1ns / 1ps
module run_length_to_bitmap_expander_top_tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [rle_pkg::RUN_W-1:0] run_length = '0;
  logic is_eol = 1'b0;
  logic out_stall = 1'b1;
  logic in_stall;
  logic out_valid;
  logic [63:0] packed_bytes;
  logic [3:0] byte_count;
  logic last_of_run;
  logic run_clipped;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  logic tx_slow = 1'b1;
  logic rx_slow = 1'b1;

  run_length_to_bitmap_expander_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .run_length   (run_length),
    .is_eol       (is_eol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .last_of_run  (last_of_run),
    .run_clipped  (run_clipped)
  );

  bitmap_word_checker watch (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .run_length   (run_length),
    .is_eol       (is_eol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .last_of_run  (last_of_run),
    .run_clipped  (run_clipped),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic push_item(input int unsigned len, input logic eol);
    int unsigned gap;
    gap = tx_slow ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    run_length = len[rle_pkg::RUN_W-1:0];
    is_eol = eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // one scan line: alternating runs closed by an end of line
  task automatic send_line();
    int unsigned runs;
    int unsigned pick;
    int unsigned len;
    runs = $urandom_range(1, 14);
    repeat (runs) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) len = 0;
      else if (pick < 70) len = $urandom_range(1, 16);
      else if (pick < 93) len = $urandom_range(17, 200);
      else if (pick < 97) len = $urandom_range(201, 2047);
      else len = $urandom_range(2048, 4095);
      push_item(len, 1'b0);
    end
    push_item($urandom_range(0, 4095), 1'b1);
  endtask

  task automatic send_noise();
    logic eol;
    repeat ($urandom_range(1, 4)) begin
      eol = ($urandom_range(0, 3) == 0);
      push_item(eol ? $urandom_range(0, 4095) : $urandom_range(0, 255), eol);
    end
  endtask

  initial begin
    logic drained;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push_item(0, 1'b0);    push_item(3, 1'b0);    push_item(5, 1'b0);
    push_item(0, 1'b1);    push_item(7, 1'b0);    push_item(0, 1'b1);
    push_item(1, 1'b0);    push_item(64, 1'b0);   push_item(65, 1'b0);
    push_item(4095, 1'b0); push_item(2048, 1'b0); push_item(2049, 1'b0);
    push_item(0, 1'b1);    push_item(0, 1'b1);    push_item(7, 1'b0);
    push_item(2048, 1'b0); push_item(4095, 1'b1); push_item(2047, 1'b0);
    push_item(1, 1'b0);    push_item(15, 1'b0);   push_item(16, 1'b0);
    push_item(63, 1'b0);   push_item(2730, 1'b0); push_item(1365, 1'b0);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);

    while (sent < RANDOM_ITEMS + 24) begin
      if ($urandom_range(0, 4) != 0) send_line();
      else send_noise();
      if ($urandom_range(0, 7) == 0) tx_slow = ~tx_slow;
      if (!drained && sent >= 260) begin
        drained = 1'b1;
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = rx_slow ? $urandom_range(0, 15) : 0;
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) rx_slow = ~rx_slow;
    end
  end

endmodule
